// File: rtl/core/nrmc_pkg.sv
// nrmc_pkg: types, constants and small helper functions shared by the rmc parser core.
// No dependencies; every other file in rtl/core but nrmc_fifo refers to it by scoped names.
`default_nettype none

package nrmc_pkg;

  // fraction digits kept per coordinate, and time characters looked at
  localparam int FRAC_DIGITS = 5;
  localparam int TIME_CHARS  = 10;

  // the point of hhmmss.sss is skipped, so one char fewer becomes a digit
  localparam int TIME_POINT_POS = 6;
  localparam int TIME_DIGITS = (TIME_CHARS > TIME_POINT_POS) ? TIME_CHARS - 1 : TIME_CHARS;

  localparam int SCALE   = 10 ** FRAC_DIGITS;
  localparam int FRAC_W  = $clog2(SCALE);
  localparam int E7_MULT = 10 ** (7 - FRAC_DIGITS);

  localparam int IP_W    = 15;
  localparam int INT_CAP = 19000;

  localparam logic [30:0] LAT_LIMIT = 31'd900000000;
  localparam logic [30:0] LON_LIMIT = 31'd1800000000;

  localparam logic [15:0] TALKER_RESET = 16'h474E;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // field of the sentence the parser is in
  typedef enum logic [2:0] {
    FLD_HEADER,
    FLD_TIME,
    FLD_STATUS,
    FLD_LAT,
    FLD_NS,
    FLD_LON,
    FLD_EW
  } field_t;

  // raw fix handed from the parser to the conversion pipeline
  typedef struct packed {
    logic [TIME_DIGITS-1:0][3:0] time_digits;
    logic [IP_W-1:0]             lat_ip;
    logic [FRAC_W-1:0]           lat_frac;
    logic                        lat_south;
    logic [IP_W-1:0]             lon_ip;
    logic [FRAC_W-1:0]           lon_frac;
    logic                        lon_west;
  } fix_t;

  typedef struct packed {
    logic [4:0]          hours;
    logic [5:0]          minutes;
    logic [5:0]          seconds;
    logic [9:0]          millis;
    logic signed [30:0]  latitude_e7;
    logic signed [31:0]  longitude_e7;
  } res_t;

  // weight of the fraction digit at position pos after the point
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [2:0] pos);
    logic [FRAC_W-1:0] w;
    w = FRAC_W'(1);
    for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
      if (i + int'(pos) < FRAC_DIGITS - 1) begin
        w = FRAC_W'(w * FRAC_W'(10));
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/nrmc_fifo.sv
// nrmc_fifo: small register queue with occupancy count.
// Used between parser and converter and in front of the result ports; uses no package.
`default_nettype none

module nrmc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [LW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + LW'(1);
      end else if (pop && !push) begin
        count <= count - LW'(1);
      end
    end
  end

  assign rdata = mem[rd_ptr];
  assign full  = (count == LW'(DEPTH));
  assign empty = (count == '0);
  assign level = count;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// File: rtl/core/nrmc_front.sv
// nrmc_front: byte-level sentence parser; matches the header, counts fields and
// collects time digits and raw coordinates into one fix beat. Depends on nrmc_pkg.
`default_nettype none

module nrmc_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                talker_we,
  input  wire logic [15:0]         talker_wdata,
  input  wire logic                take,
  input  wire logic [7:0]          rx_byte,
  output logic                     emit,
  output nrmc_pkg::fix_t           fix
);

  localparam int IP_W   = nrmc_pkg::IP_W;
  localparam int FRAC_W = nrmc_pkg::FRAC_W;
  localparam int TD     = nrmc_pkg::TIME_DIGITS;

  logic [15:0]                talker;
  logic                       sentence_ok, sentence_ok_next;
  nrmc_pkg::field_t           field, field_next;
  logic [2:0]                 header_pos, header_pos_next;
  logic                       after_point, after_point_next;
  logic [2:0]                 frac_count, frac_count_next;
  logic [IP_W-1:0]            ip_acc, ip_acc_next;
  logic [FRAC_W-1:0]          frac_acc, frac_acc_next;
  logic [TD-1:0][3:0]         time_digits, time_digits_next;
  logic [3:0]                 time_count, time_count_next;
  logic [IP_W-1:0]            lat_ip, lat_ip_next;
  logic [FRAC_W-1:0]          lat_frac, lat_frac_next;
  logic                       lat_south, lat_south_next;
  logic [IP_W-1:0]            lon_ip, lon_ip_next;
  logic [FRAC_W-1:0]          lon_frac, lon_frac_next;

  logic       is_digit;
  logic [3:0] dval;

  assign is_digit = (rx_byte >= nrmc_pkg::CH_ZERO) && (rx_byte <= nrmc_pkg::CH_NINE);
  assign dval     = rx_byte[3:0];

  always_comb begin
    logic [7:0]  want;
    logic [17:0] ip_wide;
    logic [3:0]  tidx;
    sentence_ok_next = sentence_ok;
    field_next       = field;
    header_pos_next  = header_pos;
    after_point_next = after_point;
    frac_count_next  = frac_count;
    ip_acc_next      = ip_acc;
    frac_acc_next    = frac_acc;
    time_digits_next = time_digits;
    time_count_next  = time_count;
    lat_ip_next      = lat_ip;
    lat_frac_next    = lat_frac;
    lat_south_next   = lat_south;
    lon_ip_next      = lon_ip;
    lon_frac_next    = lon_frac;
    ip_wide = 18'(ip_acc) * 18'd10 + 18'(dval);
    tidx = (time_count < 4'(nrmc_pkg::TIME_POINT_POS)) ? time_count : time_count - 4'd1;
    case (header_pos)
      3'd0:    want = talker[15:8];
      3'd1:    want = talker[7:0];
      3'd2:    want = nrmc_pkg::CH_R;
      3'd3:    want = nrmc_pkg::CH_M;
      3'd4:    want = nrmc_pkg::CH_C;
      default: want = nrmc_pkg::CH_COMMA;
    endcase

    if (take) begin
      if (rx_byte == nrmc_pkg::CH_DOLLAR) begin
        sentence_ok_next = 1'b1;
        field_next       = nrmc_pkg::FLD_HEADER;
        header_pos_next  = '0;
        after_point_next = 1'b0;
        frac_count_next  = '0;
        ip_acc_next      = '0;
        frac_acc_next    = '0;
        time_digits_next = '0;
        time_count_next  = '0;
        lat_ip_next      = '0;
        lat_frac_next    = '0;
        lat_south_next   = 1'b0;
        lon_ip_next      = '0;
        lon_frac_next    = '0;
      end else if (sentence_ok) begin
        case (field)
          nrmc_pkg::FLD_HEADER: begin
            if (rx_byte != want) begin
              sentence_ok_next = 1'b0;
            end else if (header_pos >= 3'd5) begin
              field_next       = nrmc_pkg::FLD_TIME;
              after_point_next = 1'b0;
              frac_count_next  = '0;
              ip_acc_next      = '0;
              frac_acc_next    = '0;
            end else begin
              header_pos_next = header_pos + 3'd1;
            end
          end
          nrmc_pkg::FLD_EW: begin
            // this byte releases the fix
            sentence_ok_next = 1'b0;
          end
          default: begin
            if (rx_byte == nrmc_pkg::CH_COMMA) begin
              if (field == nrmc_pkg::FLD_STATUS && !after_point) begin
                sentence_ok_next = 1'b0;
              end else begin
                if (field == nrmc_pkg::FLD_LAT) begin
                  lat_ip_next    = ip_acc;
                  lat_frac_next  = frac_acc;
                  lat_south_next = 1'b0;
                end
                if (field == nrmc_pkg::FLD_LON) begin
                  lon_ip_next   = ip_acc;
                  lon_frac_next = frac_acc;
                end
                case (field)
                  nrmc_pkg::FLD_TIME:   field_next = nrmc_pkg::FLD_STATUS;
                  nrmc_pkg::FLD_STATUS: field_next = nrmc_pkg::FLD_LAT;
                  nrmc_pkg::FLD_LAT:    field_next = nrmc_pkg::FLD_NS;
                  nrmc_pkg::FLD_NS:     field_next = nrmc_pkg::FLD_LON;
                  nrmc_pkg::FLD_LON:    field_next = nrmc_pkg::FLD_EW;
                  default:              field_next = field;
                endcase
                after_point_next = 1'b0;
                frac_count_next  = '0;
                ip_acc_next      = '0;
                frac_acc_next    = '0;
              end
            end else begin
              case (field)
                nrmc_pkg::FLD_TIME: begin
                  if (time_count < 4'(nrmc_pkg::TIME_CHARS)) begin
                    if (time_count != 4'(nrmc_pkg::TIME_POINT_POS)) begin
                      for (int i = 0; i < TD; i++) begin
                        if (tidx == 4'(i)) begin
                          time_digits_next[i] = is_digit ? dval : 4'd0;
                        end
                      end
                    end
                    time_count_next = time_count + 4'd1;
                  end
                end
                nrmc_pkg::FLD_STATUS: begin
                  if (!after_point) begin
                    after_point_next = 1'b1;
                    if (rx_byte != nrmc_pkg::CH_A) begin
                      sentence_ok_next = 1'b0;
                    end
                  end
                end
                nrmc_pkg::FLD_NS: begin
                  if (!after_point) begin
                    after_point_next = 1'b1;
                    lat_south_next   = (rx_byte == nrmc_pkg::CH_S);
                  end
                end
                nrmc_pkg::FLD_LAT, nrmc_pkg::FLD_LON: begin
                  if (rx_byte == nrmc_pkg::CH_POINT) begin
                    after_point_next = 1'b1;
                  end else if (is_digit) begin
                    if (!after_point) begin
                      ip_acc_next = (ip_wide > 18'(nrmc_pkg::INT_CAP)) ?
                                    IP_W'(nrmc_pkg::INT_CAP) : ip_wide[IP_W-1:0];
                    end else if (frac_count < 3'(nrmc_pkg::FRAC_DIGITS)) begin
                      frac_acc_next = frac_acc + FRAC_W'(FRAC_W'(dval) *
                                      nrmc_pkg::frac_weight(frac_count));
                      frac_count_next = frac_count + 3'd1;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    emit = take && sentence_ok && (field == nrmc_pkg::FLD_EW) &&
           (rx_byte != nrmc_pkg::CH_DOLLAR);
    fix.time_digits = time_digits;
    fix.lat_ip      = lat_ip;
    fix.lat_frac    = lat_frac;
    fix.lat_south   = lat_south;
    fix.lon_ip      = lon_ip;
    fix.lon_frac    = lon_frac;
    fix.lon_west    = (rx_byte == nrmc_pkg::CH_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      talker <= nrmc_pkg::TALKER_RESET;
    end else if (talker_we) begin
      talker <= talker_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sentence_ok <= 1'b0;
      field       <= nrmc_pkg::FLD_HEADER;
      header_pos  <= '0;
      after_point <= 1'b0;
      frac_count  <= '0;
      ip_acc      <= '0;
      frac_acc    <= '0;
      time_digits <= '0;
      time_count  <= '0;
      lat_ip      <= '0;
      lat_frac    <= '0;
      lat_south   <= 1'b0;
      lon_ip      <= '0;
      lon_frac    <= '0;
    end else begin
      sentence_ok <= sentence_ok_next;
      field       <= field_next;
      header_pos  <= header_pos_next;
      after_point <= after_point_next;
      frac_count  <= frac_count_next;
      ip_acc      <= ip_acc_next;
      frac_acc    <= frac_acc_next;
      time_digits <= time_digits_next;
      time_count  <= time_count_next;
      lat_ip      <= lat_ip_next;
      lat_frac    <= lat_frac_next;
      lat_south   <= lat_south_next;
      lon_ip      <= lon_ip_next;
      lon_frac    <= lon_frac_next;
    end
  end

  a_emit_closes: assert property (@(posedge clk) disable iff (rst) emit |=> !sentence_ok)
    else $error("sentence still open after its fix was released");

endmodule

`default_nettype wire

// File: rtl/core/nrmc_coord.sv
// nrmc_coord: five-stage lane turning ddmm.fffff (integer and fraction parts) into
// signed degrees times 1e7 with saturation. Depends on nrmc_pkg.
`default_nettype none

module nrmc_coord #(
  parameter logic [30:0] LIMIT = 31'd900000000
) (
  input  wire logic                          clk,
  input  wire logic [nrmc_pkg::IP_W-1:0]     ip,
  input  wire logic [nrmc_pkg::FRAC_W-1:0]   frac,
  input  wire logic                          neg,
  output logic signed [31:0]                 value
);

  localparam int FRAC_W = nrmc_pkg::FRAC_W;
  // floor(2^32 / 60); the quotient comes out at most one low
  localparam logic [31:0] RECIP_60 = 32'd71582788;

  logic [31:0]       deg_prod;
  logic [7:0]        s1_deg;
  logic [6:0]        s1_min;
  logic [FRAC_W-1:0] s1_frac;
  logic              s1_neg;

  logic [31:0]       x_wide;
  logic [31:0]       deg_wide;
  logic [29:0]       s2_x;
  logic [30:0]       s2_degpart;
  logic              s2_neg;

  logic [63:0]       q_prod;
  logic [24:0]       s3_q;
  logic [29:0]       s3_x;
  logic [30:0]       s3_degpart;
  logic              s3_neg;

  logic [30:0]       q60;
  logic [30:0]       rem;
  logic [24:0]       q_fix;
  logic [31:0]       sum;
  logic [30:0]       s4_mag;
  logic              s4_neg;

  // ip / 100 by reciprocal, exact for ip below 43690
  assign deg_prod = 32'(ip) * 32'd41944;

  always_ff @(posedge clk) begin
    s1_deg  <= deg_prod[29:22];
    s1_min  <= 7'(ip - 15'(32'(deg_prod[29:22]) * 32'd100));
    s1_frac <= frac;
    s1_neg  <= neg;
  end

  assign x_wide   = 32'(s1_min) * 32'd10000000 + 32'(s1_frac) * 32'(nrmc_pkg::E7_MULT);
  assign deg_wide = 32'(s1_deg) * 32'd10000000;

  always_ff @(posedge clk) begin
    s2_x       <= x_wide[29:0];
    s2_degpart <= deg_wide[30:0];
    s2_neg     <= s1_neg;
  end

  assign q_prod = 64'(s2_x) * 64'(RECIP_60);

  always_ff @(posedge clk) begin
    s3_q       <= q_prod[56:32];
    s3_x       <= s2_x;
    s3_degpart <= s2_degpart;
    s3_neg     <= s2_neg;
  end

  assign q60   = (31'(s3_q) << 6) - (31'(s3_q) << 2);
  assign rem   = 31'(s3_x) - q60;
  assign q_fix = (rem >= 31'd60) ? s3_q + 25'd1 : s3_q;
  assign sum   = 32'(s3_degpart) + 32'(q_fix);

  always_ff @(posedge clk) begin
    s4_mag <= (sum > 32'(LIMIT)) ? LIMIT : sum[30:0];
    s4_neg <= s3_neg;
  end

  always_ff @(posedge clk) begin
    value <= s4_neg ? -$signed({1'b0, s4_mag}) : $signed({1'b0, s4_mag});
  end

endmodule

`default_nettype wire

// File: rtl/core/nrmc_back.sv
// nrmc_back: conversion pipeline; assembles the UTC time and runs both coordinate
// lanes, issuing a fix only when the result queue has room. Depends on nrmc_pkg, nrmc_coord.
`default_nettype none

module nrmc_back #(
  parameter int OUT_DEPTH = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_avail,
  input  wire nrmc_pkg::fix_t                 in_fix,
  output logic                                in_take,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
  output logic                                out_push,
  output nrmc_pkg::res_t                      out_res
);

  localparam int STAGES = 5;
  localparam int TD     = nrmc_pkg::TIME_DIGITS;

  logic [STAGES-1:0] vld;
  logic [2:0]        inflight;
  logic [26:0]       tpipe [STAGES];

  logic [3:0] dg [9];
  logic [6:0] hh;
  logic [6:0] mm;
  logic [6:0] ss;
  logic [9:0] ms;
  logic [4:0] hours_sat;
  logic [5:0] minutes_sat;
  logic [5:0] seconds_sat;

  logic signed [31:0] lat_val;
  logic signed [31:0] lon_val;

  // credit check: beats in flight plus queued results never exceed the queue
  assign in_take = in_avail && ((int'(out_level) + int'(inflight)) < OUT_DEPTH);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      dg[i] = 4'd0;
    end
    for (int i = 0; i < TD; i++) begin
      dg[i] = in_fix.time_digits[i];
    end
  end

  assign hh = 7'(dg[0]) * 7'd10 + 7'(dg[1]);
  assign mm = 7'(dg[2]) * 7'd10 + 7'(dg[3]);
  assign ss = 7'(dg[4]) * 7'd10 + 7'(dg[5]);
  assign ms = 10'(dg[6]) * 10'd100 + 10'(dg[7]) * 10'd10 + 10'(dg[8]);

  assign hours_sat   = (hh > 7'd23) ? 5'd23 : hh[4:0];
  assign minutes_sat = (mm > 7'd59) ? 6'd59 : mm[5:0];
  assign seconds_sat = (ss > 7'd60) ? 6'd60 : ss[5:0];

  always_ff @(posedge clk) begin
    tpipe[0] <= {hours_sat, minutes_sat, seconds_sat, ms};
    for (int i = 1; i < STAGES; i++) begin
      tpipe[i] <= tpipe[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      inflight <= '0;
    end else begin
      vld      <= {vld[STAGES-2:0], in_take};
      inflight <= inflight + 3'(in_take) - 3'(vld[STAGES-1]);
    end
  end

  nrmc_coord #(
    .LIMIT (nrmc_pkg::LAT_LIMIT)
  ) u_lat (
    .clk   (clk),
    .ip    (in_fix.lat_ip),
    .frac  (in_fix.lat_frac),
    .neg   (in_fix.lat_south),
    .value (lat_val)
  );

  nrmc_coord #(
    .LIMIT (nrmc_pkg::LON_LIMIT)
  ) u_lon (
    .clk   (clk),
    .ip    (in_fix.lon_ip),
    .frac  (in_fix.lon_frac),
    .neg   (in_fix.lon_west),
    .value (lon_val)
  );

  assign out_push             = vld[STAGES-1];
  assign out_res.hours        = tpipe[STAGES-1][26:22];
  assign out_res.minutes      = tpipe[STAGES-1][21:16];
  assign out_res.seconds      = tpipe[STAGES-1][15:10];
  assign out_res.millis       = tpipe[STAGES-1][9:0];
  assign out_res.latitude_e7  = lat_val[30:0];
  assign out_res.longitude_e7 = lon_val;

  a_inflight_count: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(inflight))
    else $error("in-flight count disagrees with stage valids");
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(out_level) + int'(inflight)) <= OUT_DEPTH)
    else $error("result queue overcommitted");

endmodule

`default_nettype wire

// File: rtl/core/nmea_rmc_position_parser_core.sv
// nmea_rmc_position_parser_core: top level of the rmc position parser.
// Depends on nrmc_pkg, nrmc_front, nrmc_fifo, nrmc_back (and nrmc_coord below it).
`default_nettype none

// Takes one sentence byte per clock through push/full and gives one position fix
// (UTC time, latitude and longitude in degrees times 1e7) per valid RMC sentence
// through empty/pop. The byte parser runs at one byte per cycle and never stalls
// on its own; full rises only when QUEUE_DEPTH fixes wait for the converter, which
// in turn waits when its fixes in flight plus unread results reach OUT_DEPTH.
// A fix enters the fix queue on the E/W character of its sentence, runs through
// the coordinate pipeline (divide by 100, scale, reciprocal multiply by 1/60,
// correct and saturate, sign) and is then written into the result queue.
// talker_id may be rewritten only while no sentence is being parsed.
module nmea_rmc_position_parser_core #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               talker_id_we,
  input  wire logic [15:0]        talker_id,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               pop,
  output logic                    empty,
  output logic [4:0]              hours,
  output logic [5:0]              minutes,
  output logic [5:0]              seconds,
  output logic [9:0]              millis,
  output logic signed [30:0]      latitude_e7,
  output logic signed [31:0]      longitude_e7
);

  localparam int FIX_W = $bits(nrmc_pkg::fix_t);
  localparam int RES_W = $bits(nrmc_pkg::res_t);

  logic                                take;
  logic                                emit;
  nrmc_pkg::fix_t                      front_fix;
  logic [FIX_W-1:0]                    mid_rdata;
  logic                                mid_full;
  logic                                mid_empty;
  logic                                back_take;
  logic                                back_push;
  nrmc_pkg::res_t                      back_res;
  logic [RES_W-1:0]                    out_rdata;
  logic                                out_empty;
  logic                                out_pop;
  logic [$clog2(OUT_DEPTH+1)-1:0]      out_level;
  nrmc_pkg::res_t                      res;

  assign take    = push && !mid_full;
  assign full    = mid_full;
  assign out_pop = pop && !out_empty;
  assign empty   = out_empty;

  nrmc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .talker_we    (talker_id_we),
    .talker_wdata (talker_id),
    .take         (take),
    .rx_byte      (rx_byte),
    .emit         (emit),
    .fix          (front_fix)
  );

  nrmc_fifo #(
    .WIDTH (FIX_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fix_q (
    .clk   (clk),
    .rst   (rst),
    .push  (emit),
    .wdata (front_fix),
    .pop   (back_take),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty),
    .level ()
  );

  nrmc_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_avail  (!mid_empty),
    .in_fix    (nrmc_pkg::fix_t'(mid_rdata)),
    .in_take   (back_take),
    .out_level (out_level),
    .out_push  (back_push),
    .out_res   (back_res)
  );

  nrmc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .wdata (back_res),
    .pop   (out_pop),
    .rdata (out_rdata),
    .full  (),
    .empty (out_empty),
    .level (out_level)
  );

  assign res          = nrmc_pkg::res_t'(out_rdata);
  assign hours        = res.hours;
  assign minutes      = res.minutes;
  assign seconds      = res.seconds;
  assign millis       = res.millis;
  assign latitude_e7  = res.latitude_e7;
  assign longitude_e7 = res.longitude_e7;

endmodule

`default_nettype wire
